// File: hdl/sidec_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
package sidec_pkg;

	localparam int MAG_W       = 64;
	localparam int DIGITS      = 20;
	localparam int CHAR_W      = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int LEFT_W      = $clog2(DIGITS + 1);
	localparam int STEP_W      = $clog2(MAG_W);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

	// Packed BCD word, digit DIGITS-1 is the most significant
	typedef logic [DIGITS-1:0][3:0] bcd_t;

	// One converted number as it waits for the character emitter
	typedef struct packed {
		logic neg;
		bcd_t bcd;
	} conv_t;

endpackage

// File: hdl/sidec_front.sv
// Front end: take an integer, form its magnitude, convert it to BCD by shift-add-3.
module sidec_front
	import sidec_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [MAG_W-1:0] value,
	output logic                    busy,
	output logic                    push_valid,
	input  logic                    push_ready,
	output conv_t                   push_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_PUSH
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic [MAG_W-1:0]    mag_q;
	logic                neg_q;
	bcd_t                bcd_q;
	logic [DIGITS*4-1:0] adj;
	logic [MAG_W-1:0]    mag_in;

	// Form the unsigned magnitude of the incoming value
	assign mag_in = value[MAG_W-1] ? $unsigned(-value) : $unsigned(value);

	// Add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[i*4 +: 4] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
	end

	// Sequence accept, one conversion step per cycle, then hand off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						step_q  <= '0;
					end
				end
				ST_CONV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(MAG_W - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Load and shift the datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			neg_q <= value[MAG_W-1];
			mag_q <= mag_in;
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bcd_q <= bcd_t'({adj[DIGITS*4-2:0], mag_q[MAG_W-1]});
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign push_valid     = (state_q == ST_PUSH);
	assign push_data.neg  = neg_q;
	assign push_data.bcd  = bcd_q;

endmodule

// File: hdl/sidec_fifo.sv
// Short queue of converted numbers between the converter and the emitter.
module sidec_fifo
	import sidec_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
)
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  conv_t push_data,
	output logic  pop_valid,
	input  logic  pop,
	output conv_t pop_data
);

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W = $clog2(Depth + 1);

	conv_t             mem_q [Depth];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(Depth));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hdl/sidec_back.sv
// Back end: drop leading zeros, emit the sign and the digits one character a cycle.
module sidec_back
	import sidec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop,
	input  conv_t             pop_data,
	output logic              valid,
	output logic [CHAR_W-1:0] char_code,
	output logic              last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	state_t             state_q;
	logic               neg_q;
	bcd_t               bcd_q;
	logic [LEFT_W-1:0]  left_q;
	logic               valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	assign pop = (state_q == ST_IDLE) && pop_valid;

	// Hold state and the registered character outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			char_q  <= '0;
			neg_q   <= 1'b0;
			bcd_q   <= '0;
			left_q  <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						neg_q   <= pop_data.neg;
						bcd_q   <= pop_data.bcd;
						left_q  <= LEFT_W'(DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// Drop one leading zero per cycle, keep at least one digit
					if (bcd_q[DIGITS-1] == 4'd0 && left_q != LEFT_W'(1)) begin
						bcd_q  <= {bcd_q[DIGITS-2:0], 4'd0};
						left_q <= left_q - LEFT_W'(1);
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					valid_q <= 1'b1;
					char_q  <= CHAR_MINUS;
					last_q  <= 1'b0;
					state_q <= ST_DIGIT;
				end
				ST_DIGIT: begin
					valid_q <= 1'b1;
					char_q  <= CHAR_ZERO + CHAR_W'(bcd_q[DIGITS-1]);
					last_q  <= (left_q == LEFT_W'(1));
					bcd_q   <= {bcd_q[DIGITS-2:0], 4'd0};
					left_q  <= left_q - LEFT_W'(1);
					if (left_q == LEFT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign valid     = valid_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule

// File: hdl/signed_int_to_decimal_ascii.sv
// Top level: signed 64-bit integer to decimal ASCII character stream.
//
//  Channel  Signals                  Beat taken when
//  -------  -----------------------  -------------------------------
//  input    start, busy, value       start high and busy low
//  output   valid, char_code, last   valid high (one cycle per beat)
//
// The converter loads a number, runs 64 shift-add-3 steps over the magnitude
// bits and then hands the BCD word to the queue. The emitter takes the word,
// drops leading zeros (up to 19) one at a time, ends the scan, then emits the
// sign and the digits, overlapped with the next conversion.
// Reset clears all control state asynchronously; the block holds no state
// between numbers. Results cannot be stalled; busy stays high while a
// conversion runs or waits for queue space.
module signed_int_to_decimal_ascii
	import sidec_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
)
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [MAG_W-1:0] value,
	output logic                    valid,
	output logic [CHAR_W-1:0]       char_code,
	output logic                    last
);

	logic  push_valid;
	logic  push_ready;
	conv_t push_data;
	logic  pop_valid;
	logic  pop;
	conv_t pop_data;

	sidec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.busy       (busy),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sidec_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	sidec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.valid     (valid),
		.char_code (char_code),
		.last      (last)
	);

	// An accepted number keeps the converter busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("converter not busy after accepting a number");

	// A minus sign is never the final character
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && char_code == CHAR_MINUS |-> !last)
		else $error("minus sign marked as last character");

	// Characters of one number come out without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid && char_code != CHAR_MINUS)
		else $error("gap or repeated sign inside a number");

	// Every character is a minus sign or a decimal digit
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> char_code == CHAR_MINUS
			|| (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + CHAR_W'(9)))
		else $error("character code out of range");

endmodule
